### rtl/ps2m_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2m_pkg;

    localparam logic [7:0]  ACK_BYTE    = 8'hFA;
    localparam logic [7:0]  SIGN_X      = 8'h10;
    localparam logic [7:0]  SIGN_Y      = 8'h20;
    localparam logic [7:0]  BTN_LEFT    = 8'h01;
    localparam logic [7:0]  BTN_RIGHT   = 8'h02;
    localparam logic [7:0]  BTN_MIDDLE  = 8'h04;
    localparam logic [11:0] X_MAX_RESET = 12'd800;
    localparam logic [11:0] Y_MAX_RESET = 12'd600;

    localparam logic [0:0]  REG_X_MAX   = 1'b0;
    localparam logic [0:0]  REG_Y_MAX   = 1'b1;

    typedef struct packed {
        logic       done;
        logic [7:0] data;
    } frame_t;

    typedef struct packed {
        logic       line_clock;
        logic       line_data;
        logic       poll_sent;
    } sample_t;

    // A positive move stops at the bound, a negative move stops at zero.
    function automatic logic [11:0] move_axis(
        input logic [11:0] pos,
        input logic [7:0]  delta,
        input logic        neg,
        input logic [11:0] bound
    );
        logic [12:0] sum;
        logic [8:0]  mag;
        logic [11:0] res;
        sum = {1'b0, pos} + {5'b0, delta};
        mag = 9'd256 - {1'b0, delta};
        if (!neg)
        begin
            res = ({1'b0, bound} > sum) ? sum[11:0] : bound;
        end
        else
        begin
            res = ({3'b0, mag} < pos) ? (pos - {3'b0, mag}) : 12'd0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/ps2m_frame_rx.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2m_frame_rx
    import ps2m_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire sample_t sample,
    output frame_t       frame
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_WAIT_H = 2'd1;
    localparam logic [1:0] PH_WAIT_L = 2'd2;
    localparam logic [1:0] PH_UNUSED = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] count_reg, count_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] last_reg,  last_next;
    logic       done;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        last_next  = last_reg;
        done       = 1'b0;
        if ((phase_reg == PH_IDLE || phase_reg == PH_UNUSED)
            && !sample.line_clock && !sample.line_data)
        begin
            phase_next = PH_WAIT_H;
            count_next = 4'd0;
            shift_next = 8'd0;
        end
        else if (phase_reg == PH_WAIT_H && sample.line_clock)
        begin
            phase_next = PH_WAIT_L;
        end
        else if (phase_reg == PH_WAIT_L && !sample.line_clock)
        begin
            if (count_reg < 4'd8 && sample.line_data)
            begin
                shift_next = shift_reg | (8'd1 << count_reg[2:0]);
            end
            count_next = count_reg + 4'd1;
            phase_next = PH_WAIT_H;
        end
        if (count_next > 4'd9)
        begin
            phase_next = PH_IDLE;
            count_next = 4'd0;
            done       = 1'b1;
            last_next  = shift_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= 4'd0;
            shift_reg <= 8'd0;
            last_reg  <= 8'd0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            last_reg  <= last_next;
        end
    end

    assign frame.done = done;
    assign frame.data = last_next;

endmodule

`default_nettype wire

### rtl/ps2m_packet.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2m_packet
    import ps2m_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire frame_t      frame,
    input  wire logic        poll,
    input  wire logic [11:0] x_max,
    input  wire logic [11:0] y_max,
    output logic      [11:0] pos_x,
    output logic      [11:0] pos_y,
    output logic      [2:0]  buttons,
    output logic             pkt_done,
    output logic             nack
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ACK    = 3'd1;
    localparam logic [2:0] ST_STATUS = 3'd2;
    localparam logic [2:0] ST_X      = 3'd3;
    localparam logic [2:0] ST_Y      = 3'd4;

    logic [2:0]  step_reg,   step_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  movex_reg,  movex_next;
    logic [11:0] cx_reg,     cx_next;
    logic [11:0] cy_reg,     cy_next;
    logic [2:0]  btn_reg,    btn_next;

    always_comb
    begin
        step_next   = step_reg;
        status_next = status_reg;
        movex_next  = movex_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        btn_next    = btn_reg;
        pkt_done    = 1'b0;
        nack        = 1'b0;
        if (frame.done)
        begin
            unique case (step_reg)
                ST_ACK:
                begin
                    if (frame.data == ACK_BYTE)
                    begin
                        step_next = ST_STATUS;
                    end
                    else
                    begin
                        nack      = 1'b1;
                        step_next = ST_IDLE;
                    end
                end
                ST_STATUS:
                begin
                    status_next = frame.data;
                    step_next   = ST_X;
                end
                ST_X:
                begin
                    movex_next = frame.data;
                    step_next  = ST_Y;
                end
                ST_Y:
                begin
                    btn_next  = status_reg[2:0] & (BTN_LEFT[2:0] | BTN_RIGHT[2:0]
                                                   | BTN_MIDDLE[2:0]);
                    cx_next   = move_axis(cx_reg, movex_reg,
                                          (status_reg & SIGN_X) != 8'd0, x_max);
                    cy_next   = move_axis(cy_reg, frame.data,
                                          (status_reg & SIGN_Y) != 8'd0, y_max);
                    pkt_done  = 1'b1;
                    step_next = ST_IDLE;
                end
                default:
                begin
                    step_next = ST_IDLE;
                end
            endcase
        end
        if (poll)
        begin
            step_next = ST_ACK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= ST_IDLE;
            status_reg <= 8'd0;
            movex_reg  <= 8'd0;
            cx_reg     <= 12'd0;
            cy_reg     <= 12'd0;
            btn_reg    <= 3'd0;
        end
        else if (en)
        begin
            step_reg   <= step_next;
            status_reg <= status_next;
            movex_reg  <= movex_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            btn_reg    <= btn_next;
        end
    end

    assign pos_x   = cx_next;
    assign pos_y   = cy_next;
    assign buttons = btn_next;

endmodule

`default_nettype wire

### rtl/ps2_mouse_cursor_tracker.sv
// Channel | Handshake                | Payload
// input   | in_valid / in_stall      | line_clock, line_data, poll_sent
// result  | out_valid / out_stall    | pos_x, pos_y, buttons, frame and packet flags
// config  | APB write (psel/penable) | x_max at 0x0, y_max at 0x4
//
// One request is taken every cycle while in_stall is low; each request yields one result.
// Each request passes through the input register and then the result register.
// Reset clears the receiver, the packet assembler and the cursor, and sets the bounds to 800
// and 600.
// A stalled result holds; a new request is still taken while the input register is free.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_cursor_tracker
    import ps2m_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        line_clock,
    input  wire logic        line_data,
    input  wire logic        poll_sent,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [11:0] pos_x,
    output logic      [11:0] pos_y,
    output logic             left_down,
    output logic             right_down,
    output logic             middle_down,
    output logic             frame_done,
    output logic      [7:0]  frame_byte,
    output logic             packet_done,
    output logic             ack_missing,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [11:0] x_max_reg, y_max_reg;
    logic        cfg_write;

    logic        s1_valid_reg;
    sample_t     s1_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        step_en;
    logic        in_take;

    frame_t      frame;
    logic [11:0] px, py;
    logic [2:0]  btn;
    logic        pkt_done, nack;

    logic [11:0] pos_x_reg, pos_y_reg;
    logic [2:0]  btn_reg;
    logic        fdone_reg, pdone_reg, nack_reg;
    logic [7:0]  fbyte_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_max_reg <= X_MAX_RESET;
            y_max_reg <= Y_MAX_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_X_MAX: x_max_reg <= pwdata[11:0];
                REG_Y_MAX: y_max_reg <= pwdata[11:0];
                default:   x_max_reg <= x_max_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_X_MAX: prdata = {20'd0, x_max_reg};
            REG_Y_MAX: prdata = {20'd0, y_max_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign step_en  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_reg.line_clock <= line_clock;
            s1_reg.line_data  <= line_data;
            s1_reg.poll_sent  <= poll_sent;
        end
    end

    ps2m_frame_rx u_rx (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (step_en),
        .sample (s1_reg),
        .frame  (frame)
    );

    ps2m_packet u_pkt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (step_en),
        .frame    (frame),
        .poll     (s1_reg.poll_sent),
        .x_max    (x_max_reg),
        .y_max    (y_max_reg),
        .pos_x    (px),
        .pos_y    (py),
        .buttons  (btn),
        .pkt_done (pkt_done),
        .nack     (nack)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            pos_x_reg <= px;
            pos_y_reg <= py;
            btn_reg   <= btn;
            fdone_reg <= frame.done;
            fbyte_reg <= frame.data;
            pdone_reg <= pkt_done;
            nack_reg  <= nack;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign left_down   = btn_reg[0];
    assign right_down  = btn_reg[1];
    assign middle_down = btn_reg[2];
    assign frame_done  = fdone_reg;
    assign frame_byte  = fbyte_reg;
    assign packet_done = pdone_reg;
    assign ack_missing = nack_reg;

    a_pkt_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pdone_reg |-> fdone_reg)
        else $error("packet applied without a completed frame");

    a_nack_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && nack_reg |-> fdone_reg && !pdone_reg)
        else $error("missing acknowledge flagged without a lone frame");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled while the pipeline has room");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("processed request produced no result");

endmodule

`default_nettype wire
